@@ src/tcf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt filter package
// Shared constants, register and axis codes, and the arcsine table that is
// built at elaboration time.
// ----------------------------------------------------------------------------
package tcf_pkg;

    localparam int ASIN_TABLE_DEPTH = 256;
    localparam int ASIN_IDX_W       = $clog2(ASIN_TABLE_DEPTH + 1);
    localparam int ASIN_VAL_W       = 14;
    localparam int HALF_PI_Q13      = 12868;
    localparam int ANGLE_LIMIT      = 16384;

    typedef logic [ASIN_VAL_W-1:0] t_asin_tab [0:ASIN_TABLE_DEPTH];

    typedef enum logic [1:0] {
        REG_ANGLE_AXIS   = 2'd0,
        REG_RATE_AXIS    = 2'd1,
        REG_BLEND_WEIGHT = 2'd2
    } t_reg_index;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam longint unsigned Q30_ONE = 64'd1 << 30;

    // Sine of a Q13 angle in the first quadrant, Q30 result, Taylor series
    // evaluated in Horner form up to the thirteenth power.
    function automatic longint unsigned sin_q30(input longint unsigned a13);
        longint unsigned a;
        longint unsigned sq;
        longint unsigned t;
        a  = a13 << 17;
        sq = (a * a) >> 30;
        t  = Q30_ONE;
        t  = Q30_ONE - ((sq * t) >> 30) / 156;
        t  = Q30_ONE - ((sq * t) >> 30) / 110;
        t  = Q30_ONE - ((sq * t) >> 30) / 72;
        t  = Q30_ONE - ((sq * t) >> 30) / 42;
        t  = Q30_ONE - ((sq * t) >> 30) / 20;
        t  = Q30_ONE - ((sq * t) >> 30) / 6;
        return (a * t) >> 30;
    endfunction

    // Each entry is the Q13 angle whose sine lies nearest k/DEPTH; a tie
    // resolves to the smaller angle.
    function automatic t_asin_tab asin_build();
        t_asin_tab       tab;
        longint unsigned target;
        longint          lo;
        longint          hi;
        longint          mid;
        longint          s_lo;
        longint          s_pr;
        for (int k = 0; k <= ASIN_TABLE_DEPTH; k++) begin
            target = (longint'(k) << 30) / ASIN_TABLE_DEPTH;
            lo = 0;
            hi = HALF_PI_Q13;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (sin_q30(mid) >= target) begin
                    hi = mid;
                end else begin
                    lo = mid + 1;
                end
            end
            if (lo > 0) begin
                s_lo = longint'(sin_q30(lo));
                s_pr = longint'(sin_q30(lo - 1));
                if (longint'(target) - s_pr <= s_lo - longint'(target)) begin
                    lo = lo - 1;
                end
            end
            tab[k] = lo[ASIN_VAL_W-1:0];
        end
        return tab;
    endfunction

endpackage
`default_nettype wire

@@ src/tilt_complementary_filter.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt complementary filter
// Turns one accelerometer axis into a tilt angle through an arcsine table and
// blends it with the gyro-integrated previous angle.
// ----------------------------------------------------------------------------
// Each sample is worked through one shared multiply-accumulate unit under a
// small sequencer, so the block takes one beat at a time. A sample that gives
// a result occupies the input from acceptance to the next acceptance through
// one lookup multiply, the table interpolation, five multiplies for the
// blend, a scaling step, one reciprocal multiply for the division by 125 and
// a step to load the output register. The first sample after reset only
// seeds the state, after the lookup and the interpolation. The result
// sits in an output register, so the next sample is taken while it waits;
// should that register still be full when the next result is ready, the
// sequencer holds until it is emptied.
module tilt_complementary_filter
    import tcf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [16:0]        i_cfg_data,

    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_x,
    input  logic signed [15:0] i_gyro_y,
    input  logic signed [15:0] i_gyro_z,
    input  logic [9:0]         i_interval_ms,

    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_angle_x,
    output logic signed [15:0] o_angle_y,
    output logic signed [15:0] o_angle_z,
    output logic signed [15:0] o_rate_x,
    output logic signed [15:0] o_rate_y,
    output logic signed [15:0] o_rate_z
);

    localparam int MUL_A_W     = 28;
    localparam int MUL_B_W     = 25;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int MAC_W       = 46;
    localparam int ASIN_P_W    = 15 + ASIN_IDX_W;
    localparam int ANGLE_SCALE = 125;
    localparam int BLEND_HALF  = 4096000;
    localparam int SCALE_LIMIT = 2048000;
    localparam int RECIP_125   = 4294968;
    localparam int RECIP_SHIFT = 29;

    localparam logic [16:0]       WEIGHT_ONE = 17'd65536;
    localparam t_asin_tab         ASIN_TAB   = asin_build();

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOOKUP,
        S_ASIN,
        S_RATE,
        S_ANGLE,
        S_WCOEF,
        S_WKEEP,
        S_WACC,
        S_SCALE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state              r_state;
    logic [1:0]          r_angle_axis;
    logic [1:0]          r_rate_axis;
    logic [16:0]         r_blend_weight;
    logic                r_seeded;
    logic signed [15:0]  r_angle_est;
    logic signed [15:0]  r_prev_rate;
    logic                r_out_valid;

    logic [14:0]         r_mag;
    logic                r_neg;
    logic signed [15:0]  r_rate;
    logic [9:0]          r_interval;
    logic signed [MAC_W-1:0] r_mac;
    logic [22:0]         r_wt;
    logic signed [15:0]  r_acc_ang;
    logic [21:0]         r_q;

    logic signed [15:0]  r_angle_x;
    logic signed [15:0]  r_angle_y;
    logic signed [15:0]  r_angle_z;
    logic signed [15:0]  r_rate_x;
    logic signed [15:0]  r_rate_y;
    logic signed [15:0]  r_rate_z;

    logic signed [15:0]  accel_sel;
    logic signed [15:0]  accel_clamp;
    logic [14:0]         mag_in;
    logic signed [15:0]  rate_sel;

    logic [ASIN_P_W-1:0]   pos;
    logic [ASIN_IDX_W-1:0] idx;
    logic [ASIN_IDX_W-1:0] idx_next;
    logic [13:0]           frac;
    logic [ASIN_VAL_W-1:0] tab_lo;
    logic [ASIN_VAL_W-1:0] tab_hi;
    logic [ASIN_VAL_W-1:0] diff;
    logic [27:0]           interp;
    logic [14:0]           asin_mag;
    logic signed [15:0]    acc_ang;

    logic [16:0]           w_sat;
    logic [16:0]           w_keep;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [MUL_P_W-1:0] mul_p;

    logic signed [MAC_W-1:0]   q_sum;
    logic signed [MAC_W-1:0]   q_shift;
    logic signed [22:0]        q_clamp;
    logic [15:0]               quotient;
    logic signed [15:0]        angle_new;

    // Sample selection and clamping to one g.
    always_comb begin
        case (r_angle_axis)
            AXIS_X:  accel_sel = i_accel_x;
            AXIS_Y:  accel_sel = i_accel_y;
            AXIS_Z:  accel_sel = i_accel_z;
            default: accel_sel = '0;
        endcase
        case (r_rate_axis)
            AXIS_X:  rate_sel = i_gyro_x;
            AXIS_Y:  rate_sel = i_gyro_y;
            AXIS_Z:  rate_sel = i_gyro_z;
            default: rate_sel = '0;
        endcase
        if (accel_sel > 16'sd16384) begin
            accel_clamp = 16'sd16384;
        end else if (accel_sel < -16'sd16384) begin
            accel_clamp = -16'sd16384;
        end else begin
            accel_clamp = accel_sel;
        end
        mag_in = accel_clamp[15] ? 15'(-accel_clamp) : accel_clamp[14:0];
    end

    // Table interpolation. The table is monotonic, so the step is never negative.
    always_comb begin
        pos      = ASIN_P_W'(r_mag) * ASIN_P_W'(ASIN_TABLE_DEPTH);
        idx      = pos[14 +: ASIN_IDX_W];
        frac     = pos[13:0];
        idx_next = (idx == ASIN_IDX_W'(ASIN_TABLE_DEPTH)) ? idx : idx + 1'b1;
        tab_lo   = ASIN_TAB[idx];
        tab_hi   = ASIN_TAB[idx_next];
        diff     = tab_hi - tab_lo;
        interp   = (r_mac[27:0] + 28'd8192) >> 14;
        asin_mag = 15'(tab_lo) + 15'(interp[13:0]);
        acc_ang  = r_neg ? -16'(asin_mag) : 16'(asin_mag);
    end

    always_comb begin
        w_sat  = (r_blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : r_blend_weight;
        w_keep = WEIGHT_ONE - w_sat;
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        case (r_state)
            S_LOOKUP: begin
                mul_a = MUL_A_W'(diff);
                mul_b = MUL_B_W'(frac);
            end
            S_RATE: begin
                mul_a = MUL_A_W'(r_prev_rate);
                mul_b = MUL_B_W'(r_interval);
            end
            S_ANGLE: begin
                mul_a = MUL_A_W'(r_angle_est);
                mul_b = MUL_B_W'(ANGLE_SCALE);
            end
            S_WCOEF: begin
                mul_a = MUL_A_W'(w_sat);
                mul_b = MUL_B_W'(ANGLE_SCALE);
            end
            S_WKEEP: begin
                mul_a = r_mac[MUL_A_W-1:0];
                mul_b = MUL_B_W'(w_keep);
            end
            S_WACC: begin
                mul_a = MUL_A_W'(r_acc_ang);
                mul_b = MUL_B_W'(r_wt);
            end
            S_DIV: begin
                mul_a = MUL_A_W'(r_q);
                mul_b = MUL_B_W'(RECIP_125);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // The divisor 8192000 is 65536 times 125: a floor shift first, then a
    // reciprocal multiply on a value offset to be non-negative. Clamping
    // before the divide gives the same saturation as clamping after it.
    always_comb begin
        q_sum   = r_mac + MAC_W'(BLEND_HALF);
        q_shift = q_sum >>> 16;
        if (q_shift > MAC_W'(SCALE_LIMIT)) begin
            q_clamp = 23'(SCALE_LIMIT);
        end else if (q_shift < -MAC_W'(SCALE_LIMIT)) begin
            q_clamp = -23'(SCALE_LIMIT);
        end else begin
            q_clamp = q_shift[22:0];
        end
        quotient  = mul_p[RECIP_SHIFT +: 16];
        angle_new = 16'(quotient - 16'(ANGLE_LIMIT));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_angle_axis   <= AXIS_X;
            r_rate_axis    <= AXIS_Y;
            r_blend_weight <= 17'd1311;
            r_seeded       <= 1'b0;
            r_angle_est    <= '0;
            r_prev_rate    <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ANGLE_AXIS:   r_angle_axis   <= i_cfg_data[1:0];
                    REG_RATE_AXIS:    r_rate_axis    <= i_cfg_data[1:0];
                    REG_BLEND_WEIGHT: r_blend_weight <= i_cfg_data;
                    default: ;
                endcase
            end

            // While emitting, the output register is reloaded below instead.
            if (r_out_valid && !i_out_stall && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_mag      <= mag_in;
                        r_neg      <= (accel_clamp > 16'sd0);
                        r_rate     <= rate_sel;
                        r_interval <= i_interval_ms;
                        r_state    <= S_LOOKUP;
                    end
                end
                S_LOOKUP: begin
                    r_mac   <= MAC_W'(mul_p);
                    r_state <= S_ASIN;
                end
                S_ASIN: begin
                    r_acc_ang <= acc_ang;
                    if (!r_seeded) begin
                        r_angle_est <= acc_ang;
                        r_prev_rate <= r_rate;
                        r_seeded    <= 1'b1;
                        r_state     <= S_IDLE;
                    end else begin
                        r_state <= S_RATE;
                    end
                end
                S_RATE: begin
                    r_mac   <= MAC_W'(mul_p);
                    r_state <= S_ANGLE;
                end
                S_ANGLE: begin
                    r_mac   <= r_mac + MAC_W'(mul_p);
                    r_state <= S_WCOEF;
                end
                S_WCOEF: begin
                    r_wt    <= mul_p[22:0];
                    r_state <= S_WKEEP;
                end
                S_WKEEP: begin
                    r_mac   <= MAC_W'(mul_p);
                    r_state <= S_WACC;
                end
                S_WACC: begin
                    r_mac   <= r_mac + MAC_W'(mul_p);
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_q     <= 22'(q_clamp + 23'(SCALE_LIMIT));
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_angle_est <= angle_new;
                    r_prev_rate <= r_rate;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_angle_x   <= (r_angle_axis == AXIS_X) ? r_angle_est : '0;
                        r_angle_y   <= (r_angle_axis == AXIS_Y) ? r_angle_est : '0;
                        r_angle_z   <= (r_angle_axis == AXIS_Z) ? r_angle_est : '0;
                        r_rate_x    <= (r_rate_axis == AXIS_X) ? r_rate : '0;
                        r_rate_y    <= (r_rate_axis == AXIS_Y) ? r_rate : '0;
                        r_rate_z    <= (r_rate_axis == AXIS_Z) ? r_rate : '0;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_angle_x   = r_angle_x;
    assign o_angle_y   = r_angle_y;
    assign o_angle_z   = r_angle_z;
    assign o_rate_x    = r_rate_x;
    assign o_rate_y    = r_rate_y;
    assign o_rate_z    = r_rate_z;

endmodule
`default_nettype wire

@@ src/tcf_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Tilt filter port checker
// Watches the top-level ports for handshake and result-format slips.
// ----------------------------------------------------------------------------
module tcf_checker
    import tcf_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [15:0] o_angle_x,
    input logic signed [15:0] o_angle_y,
    input logic signed [15:0] o_angle_z,
    input logic signed [15:0] o_rate_x,
    input logic signed [15:0] o_rate_y,
    input logic signed [15:0] o_rate_z
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            ($stable(o_angle_x) && $stable(o_angle_y) && $stable(o_angle_z) &&
             $stable(o_rate_x) && $stable(o_rate_y) && $stable(o_rate_z)))
        else $error("stalled result beat changed");

    // The angle saturates at two radians on every slot.
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            (o_angle_x <= 16'sd16384 && o_angle_x >= -16'sd16384 &&
             o_angle_y <= 16'sd16384 && o_angle_y >= -16'sd16384 &&
             o_angle_z <= 16'sd16384 && o_angle_z >= -16'sd16384))
        else $error("angle beyond saturation limit");

    // Only the configured slot may carry a value.
    a_one_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
            ($countones({o_angle_x != 16'sd0, o_angle_y != 16'sd0,
                         o_angle_z != 16'sd0}) <= 1 &&
             $countones({o_rate_x != 16'sd0, o_rate_y != 16'sd0,
                         o_rate_z != 16'sd0}) <= 1))
        else $error("more than one output slot filled");

    // A sample keeps the sequencer busy for at least the following cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken again straight after a beat");

endmodule

bind tilt_complementary_filter tcf_checker u_tcf_checker (.*);
`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Tilt complementary filter testbench
// Feeds IMU samples through the valid/stall input channel under random gaps
// and output stalls, and re-programmes the axis and weight registers between
// phases. A scoreboard works out the expected angle and rate for every
// accepted sample but the seeding one, from its own arcsine table and blend
// arithmetic, and checks each result against the oldest prediction in turn.
// ----------------------------------------------------------------------------
module testbench;
    import tcf_pkg::*;

    localparam logic [1:0] REG_UNUSED  = 2'd3;
    localparam logic [1:0] AXIS_NONE   = 2'd3;
    localparam int         LIMIT_CYCLES = 1000000;
    localparam int         SETTLE_CYCLES = 24;
    localparam int         DRAIN_CYCLES  = 40;
    localparam int         RANDOM_PHASES = 12;
    localparam int         PHASE_SAMPLES = 142;

    typedef struct packed {
        logic [2:0][15:0] accel;
        logic [2:0][15:0] gyro;
        logic [9:0]       interval;
    } t_imu_sample;

    typedef struct packed {
        logic [2:0][15:0] angle;
        logic [2:0][15:0] rate;
    } t_tilt_result;

    class tilt_scoreboard;
        bit [1:0]           angle_sel;
        bit [1:0]           rate_sel;
        bit [16:0]          weight;
        logic signed [15:0] angle_est;
        logic signed [15:0] prev_rate;
        bit                 seeded;
        int                 asin_q13 [0:ASIN_TABLE_DEPTH];
        t_tilt_result       pending_tilt [$];
        int                 errors;
        int                 results_seen;

        function new();
            angle_sel    = AXIS_X;
            rate_sel     = AXIS_Y;
            weight       = 17'd1311;
            angle_est    = '0;
            prev_rate    = '0;
            seeded       = 1'b0;
            errors       = 0;
            results_seen = 0;
            build_asin();
        endfunction

        function void report(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // Taylor series of the sine up to the thirteenth power, nested from
        // the highest term down, all in Q30.
        function longint unsigned sine_q30(longint unsigned ang_q13);
            longint unsigned x;
            longint unsigned x2;
            longint unsigned poly;
            x    = ang_q13 << 17;
            x2   = (x * x) >> 30;
            poly = 64'd1 << 30;
            for (int k = 6; k >= 1; k--) begin
                poly = (64'd1 << 30) - ((x2 * poly) >> 30) / longint'((2 * k + 1) * (2 * k));
            end
            return (x * poly) >> 30;
        endfunction

        function void build_asin();
            longint unsigned goal;
            longint          lo;
            longint          hi;
            longint          mid;
            for (int k = 0; k <= ASIN_TABLE_DEPTH; k++) begin
                goal = (longint'(k) << 30) / ASIN_TABLE_DEPTH;
                lo   = 0;
                hi   = HALF_PI_Q13;
                while (lo < hi) begin
                    mid = (lo + hi) / 2;
                    if (sine_q30(mid) >= goal) begin
                        hi = mid;
                    end else begin
                        lo = mid + 1;
                    end
                end
                // Step back one code when the lower angle is at least as close.
                if (lo > 0) begin
                    if (longint'(goal) - longint'(sine_q30(lo - 1)) <=
                        longint'(sine_q30(lo)) - longint'(goal)) begin
                        lo = lo - 1;
                    end
                end
                asin_q13[k] = int'(lo);
            end
        endfunction

        function int arcsine(int x);
            int     mag;
            int     idx;
            int     frac;
            int     r;
            longint span;
            mag  = x < 0 ? -x : x;
            idx  = (mag * ASIN_TABLE_DEPTH) >> 14;
            frac = (mag * ASIN_TABLE_DEPTH) & 16383;
            if (idx >= ASIN_TABLE_DEPTH) begin
                r = asin_q13[ASIN_TABLE_DEPTH];
            end else begin
                span = longint'(asin_q13[idx + 1] - asin_q13[idx]) * frac;
                r    = asin_q13[idx] + int'((span + 8192) >>> 14);
            end
            return x < 0 ? -r : r;
        endfunction

        function longint floor_div(longint n, longint d);
            longint q;
            q = n / d;
            if ((n % d != 0) && (n < 0)) begin
                q = q - 1;
            end
            return q;
        endfunction

        function void write_reg(logic [1:0] idx, logic [16:0] data);
            case (idx)
                REG_ANGLE_AXIS:   angle_sel = data[1:0];
                REG_RATE_AXIS:    rate_sel  = data[1:0];
                REG_BLEND_WEIGHT: weight    = data;
                default: ;
            endcase
        endfunction

        function void note_sample(t_imu_sample s);
            int           a;
            int           acc;
            int           rate;
            longint       w;
            longint       num;
            longint       next_angle;
            t_tilt_result exp_tilt;
            a    = (angle_sel != AXIS_NONE) ? int'($signed(s.accel[angle_sel])) : 0;
            a    = a > 16384 ? 16384 : (a < -16384 ? -16384 : a);
            acc  = arcsine(-a);
            rate = (rate_sel != AXIS_NONE) ? int'($signed(s.gyro[rate_sel])) : 0;
            if (!seeded) begin
                angle_est = acc[15:0];
                prev_rate = rate[15:0];
                seeded    = 1'b1;
                return;
            end
            w   = weight > 17'd65536 ? 65536 : longint'(weight);
            num = (65536 - w) * (longint'(angle_est) * 125
                  + longint'(prev_rate) * longint'(s.interval))
                  + w * 125 * longint'(acc);
            next_angle = floor_div(num + 4096000, 8192000);
            if (next_angle > ANGLE_LIMIT) begin
                next_angle = ANGLE_LIMIT;
            end
            if (next_angle < -ANGLE_LIMIT) begin
                next_angle = -ANGLE_LIMIT;
            end
            angle_est = next_angle[15:0];
            prev_rate = rate[15:0];
            for (int j = 0; j < 3; j++) begin
                exp_tilt.angle[j] = (j == angle_sel) ? angle_est : 16'd0;
                exp_tilt.rate[j]  = (j == rate_sel) ? rate[15:0] : 16'd0;
            end
            pending_tilt.push_back(exp_tilt);
        endfunction

        function void check_result(t_tilt_result got);
            t_tilt_result exp_tilt;
            string        slot;
            results_seen++;
            if (pending_tilt.size() == 0) begin
                report($sformatf("result %0d arrived with no sample outstanding",
                                 results_seen));
                return;
            end
            exp_tilt = pending_tilt.pop_front();
            for (int j = 0; j < 3; j++) begin
                slot = (j == 0) ? "x" : ((j == 1) ? "y" : "z");
                if (got.angle[j] !== exp_tilt.angle[j]) begin
                    report($sformatf("result %0d angle_%s got %0d expected %0d",
                                     results_seen, slot, $signed(got.angle[j]),
                                     $signed(exp_tilt.angle[j])));
                end
                if (got.rate[j] !== exp_tilt.rate[j]) begin
                    report($sformatf("result %0d rate_%s got %0d expected %0d",
                                     results_seen, slot, $signed(got.rate[j]),
                                     $signed(exp_tilt.rate[j])));
                end
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_valid   = 1'b0;
    logic               o_cfg_ready;
    logic [1:0]         i_cfg_index   = '0;
    logic [16:0]        i_cfg_data    = '0;
    logic               i_in_valid    = 1'b0;
    logic               o_in_stall;
    logic signed [15:0] i_accel_x     = '0;
    logic signed [15:0] i_accel_y     = '0;
    logic signed [15:0] i_accel_z     = '0;
    logic signed [15:0] i_gyro_x      = '0;
    logic signed [15:0] i_gyro_y      = '0;
    logic signed [15:0] i_gyro_z      = '0;
    logic [9:0]         i_interval_ms = '0;
    logic               o_out_valid;
    logic               i_out_stall   = 1'b1;
    logic signed [15:0] o_angle_x;
    logic signed [15:0] o_angle_y;
    logic signed [15:0] o_angle_z;
    logic signed [15:0] o_rate_x;
    logic signed [15:0] o_rate_y;
    logic signed [15:0] o_rate_z;

    tilt_scoreboard sb;
    int unsigned    cycle_count = 0;
    int unsigned    out_hold    = 0;
    bit             in_calm     = 1'b0;

    tilt_complementary_filter u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_accel_x     (i_accel_x),
        .i_accel_y     (i_accel_y),
        .i_accel_z     (i_accel_z),
        .i_gyro_x      (i_gyro_x),
        .i_gyro_y      (i_gyro_y),
        .i_gyro_z      (i_gyro_z),
        .i_interval_ms (i_interval_ms),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_angle_x     (o_angle_x),
        .o_angle_y     (o_angle_y),
        .o_angle_z     (o_angle_z),
        .o_rate_x      (o_rate_x),
        .o_rate_y      (o_rate_y),
        .o_rate_z      (o_rate_z)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("FAIL tilt_complementary_filter");
            $finish;
        end
    end

    // Output back-pressure: mostly short stalls, the odd long one, and now
    // and then a long stretch with none at all.
    always @(posedge i_clk) begin : out_stall_gen
        int unsigned r;
        if (out_hold != 0) begin
            out_hold--;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                i_out_stall <= 1'b0;
                out_hold = $urandom_range(50, 200);
            end else if (r < 35) begin
                i_out_stall <= 1'b1;
                out_hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                       : $urandom_range(0, 2);
            end else begin
                i_out_stall <= 1'b0;
                out_hold = $urandom_range(0, 4);
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_tilt_result seen;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen.angle = {o_angle_z, o_angle_y, o_angle_x};
            seen.rate  = {o_rate_z, o_rate_y, o_rate_x};
            sb.check_result(seen);
        end
    end

    function automatic t_imu_sample mk_sample(int ax, int ay, int az,
                                              int gx, int gy, int gz, int iv);
        t_imu_sample s;
        s.accel    = {az[15:0], ay[15:0], ax[15:0]};
        s.gyro     = {gz[15:0], gy[15:0], gx[15:0]};
        s.interval = iv[9:0];
        return s;
    endfunction

    // Most samples look like a real sensor near rest; the rest span the
    // full range of every field.
    function automatic t_imu_sample random_sample();
        t_imu_sample s;
        if ($urandom_range(0, 9) < 6) begin
            for (int j = 0; j < 3; j++) begin
                s.accel[j] = 16'(int'($urandom_range(0, 36000)) - 18000);
                s.gyro[j]  = 16'(int'($urandom_range(0, 8191)) - 4096);
            end
            s.interval = 10'($urandom_range(0, 20));
        end else begin
            for (int j = 0; j < 3; j++) begin
                s.accel[j] = 16'($urandom());
                s.gyro[j]  = 16'($urandom());
            end
            s.interval = 10'($urandom_range(0, 1023));
        end
        return s;
    endfunction

    function automatic int unsigned in_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (in_calm || r < 55) begin
            return 0;
        end
        return (r < 90) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    task automatic send_sample(t_imu_sample s);
        int unsigned gap;
        i_in_valid    <= 1'b1;
        i_accel_x     <= s.accel[0];
        i_accel_y     <= s.accel[1];
        i_accel_z     <= s.accel[2];
        i_gyro_x      <= s.gyro[0];
        i_gyro_y      <= s.gyro[1];
        i_gyro_z      <= s.gyro[2];
        i_interval_ms <= s.interval;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_sample(s);
        gap = in_gap();
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [16:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // The seeding sample leaves nothing to wait for, so a settle time follows
    // the last beat before the registers may be touched.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (sb.pending_tilt.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_config();
        logic [16:0] w;
        case ($urandom_range(0, 4))
            0:       w = 17'd0;
            1:       w = 17'd65536;
            2:       w = 17'($urandom_range(65537, 131071));
            3:       w = 17'($urandom_range(0, 4096));
            default: w = 17'($urandom_range(0, 131071));
        endcase
        write_reg(REG_ANGLE_AXIS, 17'($urandom_range(0, 3)));
        write_reg(REG_RATE_AXIS, 17'($urandom_range(0, 3)));
        write_reg(REG_BLEND_WEIGHT, w);
        if ($urandom_range(0, 3) == 0) begin
            write_reg(REG_UNUSED, 17'($urandom()));
        end
    endtask

    initial begin
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Reset settings: the first sample seeds the state with a negated
        // tilt, then the accelerometer and gyro extremes follow.
        send_sample(mk_sample(8192, 0, 0, 0, 1000, 0, 7));
        send_sample(mk_sample(32767, -32768, 32767, -32768, 32767, -32768, 1023));
        send_sample(mk_sample(-32768, 32767, -32768, 32767, -32768, 32767, 1023));
        send_sample(mk_sample(16384, 0, 0, 0, 0, 0, 1));
        send_sample(mk_sample(-16384, 0, 0, 0, 0, 0, 1));
        send_sample(mk_sample(16383, 100, -100, 5, -5, 5, 2));
        send_sample(mk_sample(-16383, 0, 0, 0, 0, 0, 2));
        send_sample(mk_sample(0, 0, 0, 0, 0, 0, 0));
        send_sample(mk_sample(1, 0, 0, 0, 1, 0, 0));
        send_sample(mk_sample(-1, 0, 0, 0, -1, 0, 1023));
        send_sample(mk_sample(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                              16'hAAAA, 10'h2AA));
        send_sample(mk_sample(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                              16'h5555, 10'h155));

        // Gyro only: integration runs straight into the angle limit both ways.
        wait_idle();
        write_reg(REG_BLEND_WEIGHT, 17'd0);
        send_sample(mk_sample(0, 0, 0, 0, 32767, 0, 1023));
        send_sample(mk_sample(0, 0, 0, 0, -32768, 0, 1023));
        send_sample(mk_sample(0, 0, 0, 0, -32768, 0, 1023));
        send_sample(mk_sample(0, 0, 0, 0, 0, 0, 1023));

        // No axis selected, weight beyond full scale, and a write to an
        // index that holds no register.
        wait_idle();
        write_reg(REG_ANGLE_AXIS, {15'd0, AXIS_NONE});
        write_reg(REG_RATE_AXIS, {15'd0, AXIS_NONE});
        write_reg(REG_BLEND_WEIGHT, 17'h1FFFF);
        write_reg(REG_UNUSED, 17'h1FFFF);
        send_sample(mk_sample(12000, 12000, 12000, 900, 900, 900, 10));
        send_sample(mk_sample(-12000, -12000, -12000, -900, -900, -900, 10));
        send_sample(mk_sample(32767, 32767, 32767, 32767, 32767, 32767, 1023));

        wait_idle();
        write_reg(REG_ANGLE_AXIS, {15'd0, AXIS_Z});
        write_reg(REG_RATE_AXIS, {15'd0, AXIS_X});
        write_reg(REG_BLEND_WEIGHT, 17'd65536);
        send_sample(mk_sample(0, 0, -16384, 32767, 0, 0, 5));
        send_sample(mk_sample(0, 0, 16384, -32768, 0, 0, 5));
        send_sample(mk_sample(0, 0, 9000, 1234, 0, 0, 5));

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            wait_idle();
            random_config();
            in_calm = ($urandom_range(0, 3) == 0);
            repeat (PHASE_SAMPLES) send_sample(random_sample());
        end

        i_in_valid <= 1'b0;
        while (sb.pending_tilt.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("PASS tilt_complementary_filter");
        end else begin
            $display("FAIL tilt_complementary_filter");
        end
        $finish;
    end

endmodule
